// ===== sv/rtxe_pkg.sv =====
// ----------------------------------------------------------------------------
// rtxe_pkg
// Types, constants and helpers shared by the rgba to xbm text encoder.
// ----------------------------------------------------------------------------
package rtxe_pkg;

    localparam int CFG_INDEX_W    = 8;
    localparam int CFG_DATA_W     = 16;
    localparam int CHAN_W         = 8;
    localparam int CHAR_W         = 8;
    localparam int DIM_W          = 16;
    localparam int REMAIN_W       = 30;
    localparam int COL_W          = 4;
    localparam int BYTES_PER_LINE = 12;

    localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT = 8'd1;

    localparam logic [DIM_W-1:0] RESET_WIDTH  = 16'd8;
    localparam logic [DIM_W-1:0] RESET_HEIGHT = 16'd1;

    localparam logic [17:0] DARK_LIMIT = 18'd128000;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2c;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'h0a;
    localparam logic [CHAR_W-1:0] CH_BRACE = 8'h7d;
    localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3b;
    localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;

    // one finished byte, or an overrun marker, handed from front to back
    typedef struct packed {
        logic              overrun;
        logic              line_start;
        logic              line_end;
        logic              final_byte;
        logic [CHAN_W-1:0] value;
    } t_byte_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return CH_ZERO + {4'd0, nib};
        end else begin
            return CH_LC_A + {4'd0, nib} - 8'd10;
        end
    endfunction

endpackage

// ===== sv/rtxe_pixel_if.sv =====
// ----------------------------------------------------------------------------
// rtxe_pixel_if
// Pixel channel: one rgba pixel per transfer.
// ----------------------------------------------------------------------------
interface rtxe_pixel_if;
    logic                           valid;
    logic                           ready;
    logic [rtxe_pkg::CHAN_W-1:0]    red;
    logic [rtxe_pkg::CHAN_W-1:0]    green;
    logic [rtxe_pkg::CHAN_W-1:0]    blue;
    logic [rtxe_pkg::CHAN_W-1:0]    alpha;

    modport source (output valid, output red, output green, output blue,
                    output alpha, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input alpha, output ready);
endinterface

// ===== sv/rtxe_text_if.sv =====
// ----------------------------------------------------------------------------
// rtxe_text_if
// Text channel: one character of xbm body text per transfer.
// ----------------------------------------------------------------------------
interface rtxe_text_if;
    logic                           valid;
    logic                           ready;
    logic [rtxe_pkg::CHAR_W-1:0]    text_char;
    logic                           last_of_run;
    logic                           overrun_error;

    modport source (output valid, output text_char, output last_of_run,
                    output overrun_error, input ready);
    modport sink   (input valid, input text_char, input last_of_run,
                    input overrun_error, output ready);
endinterface

// ===== sv/rtxe_cfg_if.sv =====
// ----------------------------------------------------------------------------
// rtxe_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface rtxe_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [rtxe_pkg::CFG_INDEX_W-1:0]   index;
    logic [rtxe_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/rgba_to_xbm_text_encoder_top.sv =====
// ----------------------------------------------------------------------------
// rgba_to_xbm_text_encoder_top
// RGBA pixel stream in, xbm bitmap body text out, one character per transfer.
// ----------------------------------------------------------------------------
// A pixel is taken in every cycle unless a command must go into a full queue;
// it passes a three-stage pipeline (blend products, divide by 255, luma
// threshold) and then updates the bit packer. Pixels that do not finish a
// byte produce no text. Each finished byte becomes 6 to 10 characters, sent
// one per cycle by the text sequencer while the output is ready; it fetches
// each command from the queue in its idle state, and an overrun becomes one
// NUL character. The sustained pixel rate is set by the text sequencer and
// the output channel: about one pixel per cycle for full eight-pixel bytes,
// lower for narrow rows, with QUEUE_DEPTH commands of slack between the two
// sides. A width or height write restarts the image with the new dimensions.
// ----------------------------------------------------------------------------
module rgba_to_xbm_text_encoder_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rtxe_pixel_if.sink   i_pixel,
    rtxe_cfg_if.sink     i_cfg,
    rtxe_text_if.source  o_text
);

    logic                q_push;
    logic                q_pop;
    rtxe_pkg::t_byte_cmd q_push_data;
    rtxe_pkg::t_byte_cmd q_head;
    rtxe_pkg::t_q_stat   q_stat;

    rtxe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pixel     (i_pixel),
        .i_cfg       (i_cfg),
        .i_q_stat    (q_stat),
        .o_push      (q_push),
        .o_push_data (q_push_data)
    );

    rtxe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .i_pop       (q_pop),
        .o_head      (q_head),
        .o_stat      (q_stat)
    );

    rtxe_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (q_head),
        .i_q_stat (q_stat),
        .o_pop    (q_pop),
        .o_text   (o_text)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_stat.full))
        else $error("command pushed into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_pop && q_stat.empty))
        else $error("command popped from empty queue");

    a_overrun_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_text.valid && o_text.overrun_error) |->
            (o_text.last_of_run && o_text.text_char == rtxe_pkg::CH_NUL))
        else $error("overrun result malformed");

    a_stall_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_stat.full && !q_pop && !q_push && q_stat.empty == 1'b0 && !i_pixel.ready)
            |=> !q_push || !q_stat.full)
        else $error("push while queue held full");

endmodule

// ===== sv/rtxe_front.sv =====
// ----------------------------------------------------------------------------
// rtxe_front
// Pixel pipeline: composite over white, luma threshold, bit packing and
// image position tracking; emits one command per finished byte or overrun.
// ----------------------------------------------------------------------------
module rtxe_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    rtxe_pixel_if.sink          i_pixel,
    rtxe_cfg_if.sink            i_cfg,
    input  rtxe_pkg::t_q_stat   i_q_stat,
    output logic                o_push,
    output rtxe_pkg::t_byte_cmd o_push_data
);

    // floor(x / 255) for x up to 65025
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [15:0] t;
        t = x + 16'd1 + {8'd0, x[15:8]};
        return t[15:8];
    endfunction

    logic        w_enable;
    logic        w_accept;

    logic        r_v1;
    logic        r_v2;
    logic        r_v3;
    logic [15:0] r_pr;
    logic [15:0] r_pg;
    logic [15:0] r_pb;
    logic [7:0]  r_cr;
    logic [7:0]  r_cg;
    logic [7:0]  r_cb;
    logic        r_dark;

    logic [rtxe_pkg::DIM_W-1:0]    r_width;
    logic [rtxe_pkg::DIM_W-1:0]    r_height;
    logic [rtxe_pkg::CHAN_W-1:0]   r_acc;
    logic [rtxe_pkg::DIM_W-1:0]    r_pix_col;
    logic [rtxe_pkg::REMAIN_W-1:0] r_remaining;
    logic [rtxe_pkg::COL_W-1:0]    r_byte_col;

    logic [rtxe_pkg::DIM_W-1:0]    n_width;
    logic [rtxe_pkg::DIM_W-1:0]    n_height;
    logic [16:0]                   w_w_round;
    logic [13:0]                   w_row_bytes;
    logic [rtxe_pkg::REMAIN_W-1:0] n_remaining;
    logic                          w_cfg_hit;

    logic [15:0] w_blend_r;
    logic [15:0] w_blend_g;
    logic [15:0] w_blend_b;
    logic [15:0] w_white;
    logic [17:0] w_luma;

    logic [2:0]                    w_bitpos;
    logic [rtxe_pkg::CHAN_W-1:0]   w_acc_new;
    logic [rtxe_pkg::DIM_W-1:0]    w_col_inc;
    logic                          w_row_end;
    logic                          w_overrun;
    logic                          w_byte_done;
    logic                          w_need_push;
    logic [rtxe_pkg::COL_W-1:0]    w_byte_col_inc;
    logic                          w_line_end;
    logic                          w_final;

    // ---------------- classification pipeline ----------------
    assign w_white   = 16'd255 * {8'd0, 8'd255 - i_pixel.alpha};
    assign w_blend_r = {8'd0, i_pixel.red}   * {8'd0, i_pixel.alpha} + w_white;
    assign w_blend_g = {8'd0, i_pixel.green} * {8'd0, i_pixel.alpha} + w_white;
    assign w_blend_b = {8'd0, i_pixel.blue}  * {8'd0, i_pixel.alpha} + w_white;

    assign w_luma = 18'd299 * {10'd0, r_cr} + 18'd587 * {10'd0, r_cg}
                  + 18'd114 * {10'd0, r_cb};

    assign w_enable      = !(w_need_push && i_q_stat.full);
    assign w_accept      = i_pixel.valid && w_enable;
    assign i_pixel.ready = w_enable;
    assign i_cfg.ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_enable) begin
            r_v1 <= w_accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_enable) begin
            r_pr   <= w_blend_r;
            r_pg   <= w_blend_g;
            r_pb   <= w_blend_b;
            r_cr   <= div255(r_pr);
            r_cg   <= div255(r_pg);
            r_cb   <= div255(r_pb);
            r_dark <= w_luma < rtxe_pkg::DARK_LIMIT;
        end
    end

    // ---------------- image position ----------------
    assign w_cfg_hit = i_cfg.valid && (i_cfg.index == rtxe_pkg::CFG_WIDTH
                                    || i_cfg.index == rtxe_pkg::CFG_HEIGHT);

    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        if (i_cfg.index == rtxe_pkg::CFG_WIDTH) begin
            n_width = i_cfg.data;
        end
        if (i_cfg.index == rtxe_pkg::CFG_HEIGHT) begin
            n_height = i_cfg.data;
        end
    end

    assign w_w_round   = {1'b0, n_width} + 17'd7;
    assign w_row_bytes = w_w_round[16:3];
    assign n_remaining = rtxe_pkg::REMAIN_W'({16'd0, w_row_bytes} * {14'd0, n_height});

    assign w_bitpos       = r_pix_col[2:0];
    assign w_acc_new      = r_acc | (rtxe_pkg::CHAN_W'(r_dark) << w_bitpos);
    assign w_col_inc      = r_pix_col + 16'd1;
    assign w_row_end      = w_col_inc >= r_width;
    assign w_overrun      = r_remaining == '0;
    assign w_byte_done    = (w_bitpos == 3'd7) || w_row_end;
    assign w_need_push    = r_v3 && (w_overrun || w_byte_done);
    assign w_byte_col_inc = r_byte_col + 4'd1;
    assign w_line_end     = w_byte_col_inc >= rtxe_pkg::COL_W'(rtxe_pkg::BYTES_PER_LINE);
    assign w_final        = r_remaining == rtxe_pkg::REMAIN_W'(1);

    assign o_push                 = w_need_push && !i_q_stat.full;
    assign o_push_data.overrun    = w_overrun;
    assign o_push_data.line_start = r_byte_col == '0;
    assign o_push_data.line_end   = w_line_end;
    assign o_push_data.final_byte = w_final;
    assign o_push_data.value      = w_acc_new;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= rtxe_pkg::RESET_WIDTH;
            r_height    <= rtxe_pkg::RESET_HEIGHT;
            r_acc       <= '0;
            r_pix_col   <= '0;
            r_byte_col  <= '0;
            r_remaining <= rtxe_pkg::REMAIN_W'(1);
        end else if (w_cfg_hit) begin
            // a width or height register write restarts the image
            r_width     <= n_width;
            r_height    <= n_height;
            r_acc       <= '0;
            r_pix_col   <= '0;
            r_byte_col  <= '0;
            r_remaining <= n_remaining;
        end else if (r_v3 && w_enable && !w_overrun) begin
            r_pix_col <= w_row_end ? '0 : w_col_inc;
            if (w_byte_done) begin
                r_acc       <= '0;
                r_remaining <= r_remaining - rtxe_pkg::REMAIN_W'(1);
                if (!w_final) begin
                    r_byte_col <= w_line_end ? '0 : w_byte_col_inc;
                end
            end else begin
                r_acc <= w_acc_new;
            end
        end
    end

endmodule

// ===== sv/rtxe_queue.sv =====
// ----------------------------------------------------------------------------
// rtxe_queue
// Small command queue between the pixel front and the text back end.
// ----------------------------------------------------------------------------
module rtxe_queue #(
    parameter int DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  rtxe_pkg::t_byte_cmd i_push_data,
    input  logic                i_pop,
    output rtxe_pkg::t_byte_cmd o_head,
    output rtxe_pkg::t_q_stat   o_stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    rtxe_pkg::t_byte_cmd r_mem [DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr;
    logic [CNT_W-1:0]    r_count;

    assign o_stat.full  = r_count == CNT_W'(DEPTH);
    assign o_stat.empty = r_count == '0;
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ===== sv/rtxe_back.sv =====
// ----------------------------------------------------------------------------
// rtxe_back
// Text sequencer: turns each command into its characters, one per cycle
// while the output channel is ready, through a registered output stage.
// ----------------------------------------------------------------------------
module rtxe_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rtxe_pkg::t_byte_cmd i_head,
    input  rtxe_pkg::t_q_stat   i_q_stat,
    output logic                o_pop,
    rtxe_text_if.source         o_text
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_SP0,
        ST_SP1,
        ST_SP2,
        ST_ZERO,
        ST_X,
        ST_HI,
        ST_LO,
        ST_SEP,
        ST_TAIL,
        ST_NL
    } t_state;

    t_state                      r_state;
    rtxe_pkg::t_byte_cmd         r_cmd;
    logic                        r_valid;
    logic [rtxe_pkg::CHAR_W-1:0] r_char;
    logic                        r_last;
    logic                        r_err;
    logic                        w_load_ok;
    logic                        w_emit;

    assign w_load_ok = !r_valid || o_text.ready;
    // every state but idle loads one character when the output stage is free
    assign w_emit    = w_load_ok && (r_state != ST_IDLE);
    assign o_pop     = (r_state == ST_IDLE) && !i_q_stat.empty;

    assign o_text.valid         = r_valid;
    assign o_text.text_char     = r_char;
    assign o_text.last_of_run   = r_last;
    assign o_text.overrun_error = r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_valid <= 1'b1;
            end else if (r_valid && o_text.ready) begin
                r_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (!i_q_stat.empty) begin
                        r_cmd <= i_head;
                        if (i_head.overrun) begin
                            r_state <= ST_ERR;
                        end else if (i_head.line_start) begin
                            r_state <= ST_SP0;
                        end else begin
                            r_state <= ST_ZERO;
                        end
                    end
                end
                ST_ERR: begin
                    if (w_load_ok) begin
                        r_char  <= rtxe_pkg::CH_NUL;
                        r_last  <= 1'b1;
                        r_err   <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                ST_SP0, ST_SP1, ST_SP2: begin
                    if (w_load_ok) begin
                        r_char  <= rtxe_pkg::CH_SPACE;
                        r_last  <= 1'b0;
                        r_err   <= 1'b0;
                        r_state <= (r_state == ST_SP0) ? ST_SP1 :
                                   (r_state == ST_SP1) ? ST_SP2 : ST_ZERO;
                    end
                end
                ST_ZERO: begin
                    if (w_load_ok) begin
                        r_char  <= rtxe_pkg::CH_ZERO;
                        r_last  <= 1'b0;
                        r_err   <= 1'b0;
                        r_state <= ST_X;
                    end
                end
                ST_X: begin
                    if (w_load_ok) begin
                        r_char  <= rtxe_pkg::CH_X;
                        r_last  <= 1'b0;
                        r_err   <= 1'b0;
                        r_state <= ST_HI;
                    end
                end
                ST_HI: begin
                    if (w_load_ok) begin
                        r_char  <= rtxe_pkg::hex_char(r_cmd.value[7:4]);
                        r_last  <= 1'b0;
                        r_err   <= 1'b0;
                        r_state <= ST_LO;
                    end
                end
                ST_LO: begin
                    if (w_load_ok) begin
                        r_char  <= rtxe_pkg::hex_char(r_cmd.value[3:0]);
                        r_last  <= 1'b0;
                        r_err   <= 1'b0;
                        r_state <= ST_SEP;
                    end
                end
                ST_SEP: begin
                    if (w_load_ok) begin
                        r_char  <= r_cmd.final_byte ? rtxe_pkg::CH_BRACE : rtxe_pkg::CH_COMMA;
                        r_last  <= 1'b0;
                        r_err   <= 1'b0;
                        r_state <= ST_TAIL;
                    end
                end
                ST_TAIL: begin
                    if (w_load_ok) begin
                        r_err   <= 1'b0;
                        if (r_cmd.final_byte) begin
                            r_char  <= rtxe_pkg::CH_SEMI;
                            r_last  <= 1'b0;
                            r_state <= ST_NL;
                        end else begin
                            r_char  <= r_cmd.line_end ? rtxe_pkg::CH_NL : rtxe_pkg::CH_SPACE;
                            r_last  <= 1'b1;
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_NL: begin
                    if (w_load_ok) begin
                        r_char  <= rtxe_pkg::CH_NL;
                        r_last  <= 1'b1;
                        r_err   <= 1'b0;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
